FILE: hw/rtl/sabs_pkg.sv
// Shared opcodes, word layout and controller/datapath interface types.
package sabs_pkg;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam int OP_W    = 2;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 10;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 16;

    typedef struct packed {
        logic start;
        logic probe;
        logic cmp;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_search;
        logic empty;
        logic hit;
        logic out_free;
    } t_status;

endpackage

FILE: hw/rtl/sabs_ctrl.sv
// Sequencer for append, clear and the probe/compare loop of a search.
module sabs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  sabs_pkg::t_status i_status,
    output sabs_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = i_status.is_search ? S_PROBE : S_DONE;
                end
            end
            S_PROBE: begin
                if (i_status.empty) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.probe = 1'b1;
                    n_state     = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = i_status.hit ? S_DONE : S_PROBE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_IDLE)
        else $error("ready outside idle");
    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.probe |-> !i_status.empty)
        else $error("probe on empty range");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("emit into busy output");
    a_probe_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.probe |=> r_state == S_CMP)
        else $error("probe not followed by compare");

endmodule

FILE: hw/rtl/sabs_dp.sv
// Element store, search bounds, comparator and output register.
module sabs_dp #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [sabs_pkg::OP_W-1:0]         i_op,
    input  logic [sabs_pkg::VALUE_W-1:0]      i_value,
    input  sabs_pkg::t_cmd                    i_cmd,
    output sabs_pkg::t_status                 o_status,
    output logic                              o_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    output logic [sabs_pkg::POS_W-1:0]        o_position,
    output logic                              o_overflow
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic signed [WIDTH-1:0] r_rd;
    logic signed [WIDTH-1:0] r_key;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_lo;
    logic [CW-1:0]           r_hi;
    logic [CW-1:0]           r_mid;
    logic                    r_found;
    logic                    r_ovf;
    logic                    r_o_valid;
    logic                    r_o_found;
    logic [sabs_pkg::POS_W-1:0] r_o_pos;
    logic                    r_o_ovf;

    logic [63:0]             value_ext;
    logic signed [WIDTH-1:0] in_key;
    logic [CW:0]             mid_sum;
    logic [CW-1:0]           mid;
    logic                    full;
    logic [31:0]             pos_ext;

    assign value_ext = {{32{i_value[31]}}, i_value};
    assign in_key    = value_ext[WIDTH-1:0];
    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi} - {{CW{1'b0}}, 1'b1};
    assign mid       = mid_sum[CW:1];
    assign full      = (r_count == CW'(DEPTH));
    assign pos_ext   = {{(32-CW){1'b0}}, r_mid};

    assign o_status.is_search = (i_op == sabs_pkg::OP_SEARCH);
    assign o_status.empty     = !(r_lo < r_hi);
    assign o_status.hit       = (r_rd == r_key);
    assign o_status.out_free  = !r_o_valid || i_out_ready;

    // store and read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.start && i_op == sabs_pkg::OP_APPEND && !full) begin
            r_mem[r_count[AW-1:0]] <= in_key;
        end
        if (i_cmd.probe) begin
            r_rd <= r_mem[mid[AW-1:0]];
        end
    end

    // search payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key   <= in_key;
            r_lo    <= '0;
            r_hi    <= r_count;
            r_found <= 1'b0;
            r_ovf   <= (i_op == sabs_pkg::OP_APPEND) && full;
        end
        if (i_cmd.probe) begin
            r_mid <= mid;
        end
        if (i_cmd.cmp) begin
            if (r_rd == r_key) begin
                r_found <= 1'b1;
            end else if (r_key > r_rd) begin
                r_lo <= r_mid + CW'(1);
            end else begin
                r_hi <= r_mid;
            end
        end
        if (i_cmd.emit) begin
            r_o_found <= r_found;
            r_o_pos   <= r_found ? pos_ext[sabs_pkg::POS_W-1:0] : '0;
            r_o_ovf   <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                if (i_op == sabs_pkg::OP_CLEAR) begin
                    r_count <= '0;
                end else if (i_op == sabs_pkg::OP_APPEND && !full) begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_o_valid;
    assign o_found    = r_o_found;
    assign o_position = r_o_pos;
    assign o_overflow = r_o_ovf;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count beyond depth");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !i_out_ready |=> r_o_valid && $stable(r_o_pos))
        else $error("stalled result lost");

endmodule

FILE: hw/rtl/sorted_array_binary_search.sv
// Top level: sorted-array binary search over a loaded element store.
//
// Input stream s_axis: each word is an op and a value. Append stores the
// value at the next free entry (full store: dropped, overflow flagged),
// clear empties the array, search runs a floor-midpoint binary search over
// the loaded entries. Output stream m_axis: exactly one result word per
// input word, in order: found, position of the first probed match, overflow.
// An append, clear or unused op goes from acceptance straight to the emit
// step; a search first runs P probes, P <= floor(log2(count)) + 1, until
// a hit or an empty range; each probe is one registered store read
// followed by one compare. One word is worked on at a time; s_axis_tready
// rises again as soon as its result sits in the output register, so the
// next word is taken while a result waits.
// A stalled m_axis holds its word; a finished item then waits for the
// output register, and no new word is taken meanwhile.
// Reset (i_rst_n low, synchronous) empties the array and drops any result;
// store contents are not cleared and no clearing pass is needed.
module sorted_array_binary_search #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [sabs_pkg::IN_W-1:0]   s_axis_tdata,  // op[1:0], value[33:2], zero pad
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [sabs_pkg::OUT_W-1:0]  m_axis_tdata   // found[0], position[10:1],
                                                       // overflow[11], zero pad
);

    sabs_pkg::t_cmd    cmd;
    sabs_pkg::t_status status;
    logic                       found;
    logic [sabs_pkg::POS_W-1:0] position;
    logic                       overflow;

    sabs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    sabs_dp #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (s_axis_tdata[1:0]),
        .i_value     (s_axis_tdata[33:2]),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_valid     (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_found     (found),
        .o_position  (position),
        .o_overflow  (overflow)
    );

    assign m_axis_tdata = {4'b0, overflow, position, found};

endmodule

FILE: verif/sorted_array_binary_search_tb.sv
// Self-checking testbench for sorted_array_binary_search: stream driver, result sink, predictor.
localparam int STORE_DEPTH = 1024;

typedef struct packed {
    logic                       overflow;
    logic [sabs_pkg::POS_W-1:0] position;
    logic                       found;
} t_search_result;

class array_search_tracker;
    logic signed [sabs_pkg::VALUE_W-1:0] elements [STORE_DEPTH];
    int                                  n_loaded;
    t_search_result                      pending_results [$];
    int                                  n_checked;
    int                                  errors;

    function new();
        n_loaded  = 0;
        n_checked = 0;
        errors    = 0;
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    // updates the array copy and queues the result this word must produce
    function void note_word(logic [sabs_pkg::OP_W-1:0] op,
                            logic signed [sabs_pkg::VALUE_W-1:0] value);
        t_search_result r;
        int lo, hi, mid;
        r = '0;
        case (op)
            sabs_pkg::OP_APPEND: begin
                if (n_loaded >= STORE_DEPTH) begin
                    r.overflow = 1'b1;
                end else begin
                    elements[n_loaded] = value;
                    n_loaded++;
                end
            end
            sabs_pkg::OP_SEARCH: begin
                lo = 0;
                hi = n_loaded - 1;
                while (lo <= hi && !r.found) begin
                    mid = (lo + hi) / 2;
                    if (elements[mid] == value) begin
                        r.found    = 1'b1;
                        r.position = mid[sabs_pkg::POS_W-1:0];
                    end else if (value > elements[mid]) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid - 1;
                    end
                end
            end
            sabs_pkg::OP_CLEAR: n_loaded = 0;
            default: ;
        endcase
        pending_results.push_back(r);
    endfunction

    task report(string msg);
        $display("ERROR result %0d: %s", n_checked, msg);
        errors++;
    endtask

    task check_result(logic [sabs_pkg::OUT_W-1:0] word);
        t_search_result got, want;
        got = word[$bits(t_search_result)-1:0];
        if (pending_results.size() == 0) begin
            report($sformatf("unexpected word %h", word));
        end else begin
            want = pending_results.pop_front();
            if (got.found !== want.found)
                report($sformatf("found %b, want %b", got.found, want.found));
            if (got.position !== want.position)
                report($sformatf("position %0d, want %0d", got.position, want.position));
            if (got.overflow !== want.overflow)
                report($sformatf("overflow %b, want %b", got.overflow, want.overflow));
        end
        n_checked++;
    endtask
endclass

module sorted_array_binary_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [sabs_pkg::OP_W-1:0]           OP_UNUSED = 2'd3;
    localparam logic signed [sabs_pkg::VALUE_W-1:0] VAL_MIN   = 32'sh8000_0000;
    localparam logic signed [sabs_pkg::VALUE_W-1:0] VAL_MAX   = 32'sh7FFF_FFFF;

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [sabs_pkg::IN_W-1:0]  s_axis_tdata  = '0;  // op, value, zero pad
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [sabs_pkg::OUT_W-1:0] m_axis_tdata;        // found, position, overflow, zero pad

    bit send_gaps = 1'b1;
    bit sink_gaps = 1'b1;
    bit hold_req  = 1'b0;
    bit tail      = 1'b0;
    int n_sent    = 0;
    int fill_end;

    logic signed [sabs_pkg::VALUE_W-1:0] run_vals [$];

    array_search_tracker tracker = new();

    sorted_array_binary_search #(
        .DEPTH(STORE_DEPTH),
        .WIDTH(sabs_pkg::VALUE_W)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    task automatic send_word(input logic [sabs_pkg::OP_W-1:0] op,
                             input logic signed [sabs_pkg::VALUE_W-1:0] value);
        if (send_gaps && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(sabs_pkg::IN_W-sabs_pkg::OP_W-sabs_pkg::VALUE_W){1'b0}},
                          value, op};
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_word(op, value);
        n_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    task automatic clear_run();
        send_word(sabs_pkg::OP_CLEAR, $urandom);
        run_vals.delete();
    endtask

    // ascending (non-decreasing) appends, saturating at the top of the range
    task automatic load_run(input int n, input int unsigned gap_max,
                            input logic signed [sabs_pkg::VALUE_W-1:0] start);
        logic signed [sabs_pkg::VALUE_W-1:0] v;
        longint nxt;
        v = start;
        for (int i = 0; i < n; i++) begin
            send_word(sabs_pkg::OP_APPEND, v);
            run_vals.push_back(v);
            nxt = longint'(v) + longint'($urandom_range(0, gap_max));
            if (nxt > longint'(VAL_MAX))
                nxt = longint'(VAL_MAX);
            v = nxt[sabs_pkg::VALUE_W-1:0];
        end
    endtask

    function automatic logic signed [sabs_pkg::VALUE_W-1:0] pick_loaded();
        if (run_vals.size() == 0)
            return $urandom;
        return run_vals[$urandom_range(0, run_vals.size() - 1)];
    endfunction

    task automatic search_run(input int m);
        logic signed [sabs_pkg::VALUE_W-1:0] t;
        for (int i = 0; i < m; i++) begin
            case ($urandom_range(0, 6))
                0, 1, 2: t = pick_loaded();
                3:       t = pick_loaded() + 1;
                4:       t = pick_loaded() - 1;
                5:       t = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
                default: t = $urandom;
            endcase
            send_word(sabs_pkg::OP_SEARCH, t);
        end
    endtask

    task automatic random_run();
        int n;
        int unsigned gap;
        logic signed [sabs_pkg::VALUE_W-1:0] start;
        if (!tail) begin
            send_gaps = ($urandom_range(0, 3) != 0);
            sink_gaps = ($urandom_range(0, 3) != 0);
        end
        if ($urandom_range(0, 6) == 0) begin
            // noise: any op, any value
            repeat ($urandom_range(1, 6))
                send_word(sabs_pkg::OP_W'($urandom_range(0, 3)), $urandom);
        end else begin
            if ($urandom_range(0, 4) != 0)
                clear_run();
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(0, 40);
            case ($urandom_range(0, 2))
                0:       gap = 3;
                1:       gap = 1000;
                default: gap = 1 << 24;
            endcase
            start = (n > 40) ? VAL_MIN + $urandom_range(0, 255) : $urandom;
            load_run(n, gap, start);
            search_run($urandom_range(1, 12));
        end
    endtask

    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(sabs_pkg::OP_SEARCH, 0);            // empty array
        send_word(OP_UNUSED, -1);
        send_word(sabs_pkg::OP_APPEND, VAL_MIN);
        send_word(sabs_pkg::OP_APPEND, -1);
        send_word(sabs_pkg::OP_APPEND, 0);
        send_word(sabs_pkg::OP_APPEND, 1);
        send_word(sabs_pkg::OP_APPEND, VAL_MAX);
        send_word(sabs_pkg::OP_SEARCH, VAL_MIN);
        send_word(sabs_pkg::OP_SEARCH, VAL_MAX);
        send_word(sabs_pkg::OP_SEARCH, 0);
        send_word(sabs_pkg::OP_SEARCH, 5);
        send_word(sabs_pkg::OP_SEARCH, -5);
        send_word(sabs_pkg::OP_CLEAR, VAL_MAX);
        send_word(sabs_pkg::OP_SEARCH, 0);            // empty after clear
        send_word(sabs_pkg::OP_APPEND, 7);            // out of order contents
        send_word(sabs_pkg::OP_APPEND, 3);
        send_word(sabs_pkg::OP_APPEND, 9);
        send_word(sabs_pkg::OP_SEARCH, 3);
        send_word(sabs_pkg::OP_SEARCH, 9);
        send_word(sabs_pkg::OP_SEARCH, 7);
        send_word(sabs_pkg::OP_CLEAR, 0);
        repeat (3) send_word(sabs_pkg::OP_APPEND, 4); // duplicates
        send_word(sabs_pkg::OP_SEARCH, 4);
        send_word(OP_UNUSED, 0);
        send_word(sabs_pkg::OP_SEARCH, 4);
        wait_drained();

        while (n_sent < 60)
            random_run();
        hold_req = 1'b1;                    // sink stalls while words keep coming
        while (n_sent < 100)
            random_run();
        wait_drained();

        // full store, then appends that must be dropped
        clear_run();
        load_run(STORE_DEPTH, 1 << 22, VAL_MIN);
        send_word(sabs_pkg::OP_APPEND, VAL_MAX);
        send_word(sabs_pkg::OP_APPEND, $urandom);
        send_word(sabs_pkg::OP_APPEND, VAL_MIN);
        send_word(sabs_pkg::OP_SEARCH, run_vals[0]);
        send_word(sabs_pkg::OP_SEARCH, run_vals[STORE_DEPTH-1]);
        search_run(20);
        wait_drained();
        fill_end = n_sent;

        while (n_sent < fill_end + 30)
            random_run();
        tail      = 1'b1;
        send_gaps = 1'b0;
        sink_gaps = 1'b0;
        while (n_sent < fill_end + 60)
            random_run();
        wait_drained();
        repeat (30) @(posedge i_clk);

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("sorted_array_binary_search test passed");
        else
            $display("sorted_array_binary_search test failed");
        $finish;
    end

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                tracker.check_result(m_axis_tdata);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 16);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("sorted_array_binary_search test failed");
        $finish;
    end

endmodule

FILE: sorted_array_binary_search.f
hw/rtl/sabs_pkg.sv
hw/rtl/sabs_ctrl.sv
hw/rtl/sabs_dp.sv
hw/rtl/sorted_array_binary_search.sv
verif/sorted_array_binary_search_tb.sv
